// File: hdl/bmg_pkg.sv
// Shared types, constants and tables for the Box-Muller Gaussian pair core.
// No dependencies.
`timescale 1ns / 1ps

package bmg_pkg;

  localparam int NORM_STAGES  = 6;
  localparam int LOG_STEPS    = 56;
  localparam int SQRT_STEPS   = 31;
  localparam int CORDIC_STEPS = 31;
  localparam int MANT_W       = 63;
  localparam int LZ_W         = 6;
  localparam int T_W          = 62;
  localparam int REM_W        = 35;
  localparam int ROOT_W       = 31;
  localparam int TRIG_W       = 34;

  localparam logic [63:0] LN2_Q64   = 64'hB17217F7D1CF79AC;
  localparam logic [63:0] TWOPI_Q61 = 64'hC90FDAA22168C235;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sh26DD3B6A;

  typedef struct packed {
    logic [MANT_W-1:0]    m;
    logic [LOG_STEPS-1:0] f;
    logic [LZ_W-1:0]      z;
  } log_t;

  typedef struct packed {
    logic [T_W-1:0]    x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
  } cordic_t;

  function automatic logic signed [TRIG_W-1:0] atan_q30(input int i);
    logic signed [TRIG_W-1:0] a;
    unique case (i)
      0:  a = 34'sh3243F6A8;
      1:  a = 34'sh1DAC6705;
      2:  a = 34'sh0FADBAFC;
      3:  a = 34'sh07F56EA6;
      4:  a = 34'sh03FEAB76;
      5:  a = 34'sh01FFD55B;
      6:  a = 34'sh00FFFAAA;
      7:  a = 34'sh007FFF55;
      8:  a = 34'sh003FFFEA;
      9:  a = 34'sh001FFFFD;
      10: a = 34'sh000FFFFF;
      11: a = 34'sh0007FFFF;
      12: a = 34'sh0003FFFF;
      13: a = 34'sh0001FFFF;
      14: a = 34'sh0000FFFF;
      15: a = 34'sh00007FFF;
      16: a = 34'sh00003FFF;
      17: a = 34'sh00001FFF;
      18: a = 34'sh00000FFF;
      19: a = 34'sh000007FF;
      20: a = 34'sh000003FF;
      21: a = 34'sh000001FF;
      22: a = 34'sh000000FF;
      23: a = 34'sh0000007F;
      24: a = 34'sh0000003F;
      25: a = 34'sh0000001F;
      26: a = 34'sh0000000F;
      27: a = 34'sh00000008;
      28: a = 34'sh00000004;
      29: a = 34'sh00000002;
      30: a = 34'sh00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/box_muller_gaussian_pair_core.sv
// Box-Muller Gaussian pair core: top level.
// Depends on bmg_pkg, bmg_mul128, bmg_log_cell, bmg_sqrt_cell and bmg_cordic_cell.
`timescale 1ns / 1ps

// The core takes one request of two uniform draws in every clock while it is not stalled and
// returns one Gaussian pair per request, in order. The radius path is the longer one: a
// six-stage leading-zero normalizer, 56 squaring cells for the logarithm, a multiply by
// ln 2 and 31 square-root cells; the angle runs through 31 CORDIC cells in parallel. The
// whole pipeline advances as one; it holds only while a finished result is on the output
// and the receiver stalls.
module box_muller_gaussian_pair_core
  import bmg_pkg::*;
#(
  parameter int UNIFORM_BITS  = 48,
  parameter int OUT_FRAC_BITS = 28
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [UNIFORM_BITS-1:0] in_uniform_radius,
  input  logic [UNIFORM_BITS-1:0] in_uniform_angle,
  input  logic                    in_keep_second,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [31:0]      out_gauss_sin,
  output logic signed [31:0]      out_gauss_cos,
  output logic                    out_cos_valid
);

  localparam int B       = UNIFORM_BITS;
  localparam int D_RHO   = 1 + NORM_STAGES + 2 * LOG_STEPS + 2 + SQRT_STEPS;
  localparam int ANG_DLY = D_RHO - 3 - CORDIC_STEPS;
  localparam int D_OUT   = D_RHO + 2;
  localparam int RND_SH  = 58 - OUT_FRAC_BITS;

  logic en;

  logic [B:0]          v_r;
  logic [B-1:0]        ud_r [0:ANG_DLY];
  logic                vl_r [0:D_OUT-1];
  logic                kp_r [0:D_OUT-2];
  logic [MANT_W-1:0]   nx_r [0:NORM_STAGES];
  logic [LZ_W-1:0]     nz_r [0:NORM_STAGES];
  logic [1:0]          qd_r [0:CORDIC_STEPS+1];

  log_t    lg [0:LOG_STEPS];
  sqrt_t   sq [0:SQRT_STEPS];
  cordic_t cd [0:CORDIC_STEPS];

  logic [T_W-1:0]   t_val;
  logic [127:0]     lnp, tpp;
  logic [63:0]      phase;

  logic signed [TRIG_W-1:0] s_val, c_val;
  logic signed [65:0]       rho_x, s_x, c_x;
  logic signed [65:0]       ps_r, pc_r;
  logic [31:0]              gs_r, gc_r;
  logic                     cv_r;

  function automatic logic [31:0] round_sat(input logic signed [65:0] p);
    logic signed [65:0] r;
    r = (p + (66'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    if (r > 66'sd2147483647) begin
      r = 66'sd2147483647;
    end else if (r < -66'sd2147483648) begin
      r = -66'sd2147483648;
    end
    return r[31:0];
  endfunction

  assign en       = !vl_r[D_OUT-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D_OUT; i++) begin
        vl_r[i] <= 1'b0;
      end
    end else if (en) begin
      vl_r[0] <= in_valid;
      for (int i = 1; i < D_OUT; i++) begin
        vl_r[i] <= vl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r     <= {1'b1, {B{1'b0}}} - {1'b0, in_uniform_radius};
      ud_r[0] <= in_uniform_angle;
      kp_r[0] <= in_keep_second;
      for (int i = 1; i <= ANG_DLY; i++) begin
        ud_r[i] <= ud_r[i-1];
      end
      for (int i = 1; i < D_OUT - 1; i++) begin
        kp_r[i] <= kp_r[i-1];
      end
      qd_r[0] <= phase[63:62];
      for (int i = 1; i <= CORDIC_STEPS + 1; i++) begin
        qd_r[i] <= qd_r[i-1];
      end
    end
  end

  assign nx_r[0] = {v_r, {(MANT_W-B-1){1'b0}}};
  assign nz_r[0] = '0;

  for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
    localparam int SH = 32 >> g;
    always_ff @(posedge clk) begin
      if (en) begin
        if (nx_r[g][MANT_W-1 -: SH] == '0) begin
          nx_r[g+1] <= nx_r[g] << SH;
          nz_r[g+1] <= nz_r[g] + LZ_W'(SH);
        end else begin
          nx_r[g+1] <= nx_r[g];
          nz_r[g+1] <= nz_r[g];
        end
      end
    end
  end

  assign lg[0].m = nx_r[NORM_STAGES];
  assign lg[0].f = '0;
  assign lg[0].z = nz_r[NORM_STAGES];

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    bmg_log_cell u_cell (
      .clk (clk),
      .en  (en),
      .d_i (lg[g]),
      .d_o (lg[g+1])
    );
  end

  assign t_val = {lg[LOG_STEPS].z, {LOG_STEPS{1'b0}}} - {{LZ_W{1'b0}}, lg[LOG_STEPS].f};

  bmg_mul128 u_ln2 (
    .clk (clk),
    .en  (en),
    .a   ({2'b00, t_val}),
    .b   (LN2_Q64),
    .p   (lnp)
  );

  assign sq[0].x    = lnp[125:64];
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    bmg_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d_i (sq[g]),
      .d_o (sq[g+1])
    );
  end

  assign phase = {ud_r[ANG_DLY], {(64-B){1'b0}}};

  bmg_mul128 u_twopi (
    .clk (clk),
    .en  (en),
    .a   ({2'b00, phase[61:0]}),
    .b   (TWOPI_Q61),
    .p   (tpp)
  );

  assign cd[0].x = CORDIC_GAIN;
  assign cd[0].y = '0;
  assign cd[0].z = {3'b000, tpp[125:95]};

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    bmg_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .en  (en),
      .d_i (cd[g]),
      .d_o (cd[g+1])
    );
  end

  always_comb begin
    unique case (qd_r[CORDIC_STEPS+1])
      2'd0: begin
        s_val = cd[CORDIC_STEPS].y;
        c_val = cd[CORDIC_STEPS].x;
      end
      2'd1: begin
        s_val = cd[CORDIC_STEPS].x;
        c_val = -cd[CORDIC_STEPS].y;
      end
      2'd2: begin
        s_val = -cd[CORDIC_STEPS].y;
        c_val = -cd[CORDIC_STEPS].x;
      end
      default: begin
        s_val = -cd[CORDIC_STEPS].x;
        c_val = cd[CORDIC_STEPS].y;
      end
    endcase
  end

  assign rho_x = {{(66-ROOT_W){1'b0}}, sq[SQRT_STEPS].root};
  assign s_x   = {{(66-TRIG_W){s_val[TRIG_W-1]}}, s_val};
  assign c_x   = {{(66-TRIG_W){c_val[TRIG_W-1]}}, c_val};

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r <= rho_x * s_x;
      pc_r <= rho_x * c_x;
      gs_r <= round_sat(ps_r);
      gc_r <= kp_r[D_OUT-2] ? round_sat(pc_r) : 32'd0;
      cv_r <= kp_r[D_OUT-2];
    end
  end

  assign out_valid     = vl_r[D_OUT-1];
  assign out_gauss_sin = gs_r;
  assign out_gauss_cos = gc_r;
  assign out_cos_valid = cv_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_cos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cos_valid |-> out_gauss_cos == 32'd0)
    else $error("unwanted cosine value not cleared");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

// File: hdl/bmg_mul128.sv
// Two-stage 64 by 64 bit unsigned multiplier built from 32 by 32 partial products.
// Depends on nothing.
`timescale 1ns / 1ps

module bmg_mul128 (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] p_r;
  logic [127:0] p_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[31:0] * b[31:0];
      lh_r <= a[31:0] * b[63:32];
      hl_r <= a[63:32] * b[31:0];
      hh_r <= a[63:32] * b[63:32];
      p_r  <= p_nxt;
    end
  end

  assign p_nxt = {hh_r, 64'd0} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {64'd0, ll_r};
  assign p = p_r;

endmodule

// File: hdl/bmg_log_cell.sv
// One squaring step of the log2 fraction search: square, renormalize, emit one bit.
// Depends on bmg_pkg and bmg_mul128.
`timescale 1ns / 1ps

module bmg_log_cell
  import bmg_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  log_t d_i,
  output log_t d_o
);

  logic [127:0]         sq;
  logic [63:0]          m2;
  logic [LOG_STEPS-1:0] f1_r, f2_r;
  logic [LZ_W-1:0]      z1_r, z2_r;

  bmg_mul128 u_sq (
    .clk (clk),
    .en  (en),
    .a   ({1'b0, d_i.m}),
    .b   ({1'b0, d_i.m}),
    .p   (sq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= d_i.f;
      z1_r <= d_i.z;
      f2_r <= f1_r;
      z2_r <= z1_r;
    end
  end

  assign m2     = sq[125:62];
  assign d_o.m  = m2[63] ? m2[63:1] : m2[62:0];
  assign d_o.f  = {f2_r[LOG_STEPS-2:0], m2[63]};
  assign d_o.z  = z2_r;

endmodule

// File: hdl/bmg_sqrt_cell.sv
// One digit step of the integer square root: two radicand bits in, one root bit out.
// Depends on bmg_pkg.
`timescale 1ns / 1ps

module bmg_sqrt_cell
  import bmg_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  sqrt_t d_i,
  output sqrt_t d_o
);

  sqrt_t            d_r, d_nxt;
  logic [REM_W-1:0] rem_t, trial;
  logic             ge;

  always_comb begin
    rem_t       = {d_i.rem[REM_W-3:0], d_i.x[T_W-1:T_W-2]};
    trial       = {{(REM_W-ROOT_W-2){1'b0}}, d_i.root, 2'b01};
    ge          = rem_t >= trial;
    d_nxt.rem   = ge ? rem_t - trial : rem_t;
    d_nxt.root  = {d_i.root[ROOT_W-2:0], ge};
    d_nxt.x     = {d_i.x[T_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// File: hdl/bmg_cordic_cell.sv
// One rotation step of the circular CORDIC with a fixed shift and arctangent.
// Depends on bmg_pkg.
`timescale 1ns / 1ps

module bmg_cordic_cell
  import bmg_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t d_i,
  output cordic_t d_o
);

  cordic_t                  d_r, d_nxt;
  logic signed [TRIG_W-1:0] dx, dy;

  always_comb begin
    dx = d_i.y >>> STEP;
    dy = d_i.x >>> STEP;
    if (d_i.z >= 0) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - atan_q30(STEP);
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + atan_q30(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule
